// ===== hdl/iir_df1_pkg.sv =====
// Shared types and constants for the direct-form-I biquad.
// Used by the interfaces, the controller, the datapath and the top level.
package iir_df1_pkg;

    localparam int DEF_FILTER_ORDER = 2;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int SCALE_W  = ACC_W + COEF_W;
    localparam int FRAC_W   = 24;
    localparam int Q_W      = SCALE_W - FRAC_W;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

    // register indexes
    localparam cfg_idx_t REG_B0 = 3'd0;
    localparam cfg_idx_t REG_B1 = 3'd1;
    localparam cfg_idx_t REG_B2 = 3'd2;
    localparam cfg_idx_t REG_A1 = 3'd3;
    localparam cfg_idx_t REG_A2 = 3'd4;
    localparam cfg_idx_t REG_R  = 3'd5;

    localparam coef_t COEF_ONE = 16'sd4096;

    // tap sequence of the shared multiply-accumulate
    typedef logic [2:0] tap_t;
    localparam tap_t TAP_B0 = 3'd0;
    localparam tap_t TAP_B1 = 3'd1;
    localparam tap_t TAP_B2 = 3'd2;
    localparam tap_t TAP_A1 = 3'd3;
    localparam tap_t TAP_A2 = 3'd4;

    localparam logic signed [Q_W-1:0] Y_MAX = Q_W'(32767);
    localparam logic signed [Q_W-1:0] Y_MIN = -Q_W'(32768);

    typedef struct packed {
        logic load;    // capture a new sample, clear the accumulator
        logic mac;     // multiply-accumulate one tap
        tap_t tap;     // tap for mac
        logic scale;   // multiply the sum by the reciprocal
        logic commit;  // round, saturate, update history and output register
    } dp_cmd_t;

endpackage

// ===== hdl/iir_df1_ifs.sv =====
// Channel interfaces: sample input, result output and register write.
// Depends on iir_df1_pkg.
interface iir_df1_in_if
    import iir_df1_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface iir_df1_out_if
    import iir_df1_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t sample_out;
    logic    clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

interface iir_df1_cfg_if
    import iir_df1_pkg::*;
();
    logic     valid;
    logic     ready;
    cfg_idx_t index;
    coef_t    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/iir_direct_form_one_filter.sv =====
// Direct-form-I IIR biquad, top level: sequencer plus datapath.
// Depends on iir_df1_pkg, the channel interfaces, iir_df1_ctrl and iir_df1_dp.
//
//   channel   dir   payload                      item
//   samples   in    sample_in[15:0] signed       one input sample
//   results   out   sample_out[15:0], clipped    one filtered sample
//   cfg       in    index[2:0], data[15:0]       one register write
//
// Each sample goes through acceptance, five steps of the single
// 16x16 multiply-accumulate (b0, b1, b2, a1, a2), one step of the 34x16
// reciprocal multiply, and a last step to round, saturate and update history.
// Reset restores b0 = r = 1.0, other coefficients zero, history zero.
// The output register holds a result until taken; a new sample is accepted
// meanwhile, and the commit cycle stalls only if the previous result still waits.
// Register writes are accepted on every cycle and must land while idle.
module iir_direct_form_one_filter
    import iir_df1_pkg::*;
#(
    parameter int FILTER_ORDER = DEF_FILTER_ORDER
)
(
    input  logic          clk,
    input  logic          rst_n,
    iir_df1_in_if.sink    samples,
    iir_df1_out_if.source results,
    iir_df1_cfg_if.sink   cfg
);

    dp_cmd_t cmd;

    // register writes are always taken
    assign cfg.ready = 1'b1;

    iir_df1_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .cmd       (cmd)
    );

    iir_df1_dp #(
        .FILTER_ORDER (FILTER_ORDER)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sample_in  (samples.sample_in),
        .cfg_we     (cfg.valid),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .sample_out (results.sample_out),
        .clipped    (results.clipped)
    );

`ifndef ASSERT_OFF
    // one item in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.ready |=> !samples.ready)
        else $error("sample accepted while another is in work");

    // a commit always leaves a result on the output
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> results.valid)
        else $error("committed result not presented");

    // a clipped result sits on a rail
    a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.clipped |->
            (results.sample_out == 16'sh7fff || results.sample_out == 16'sh8000))
        else $error("clipped flag without a saturated value");

    // no two datapath commands (load, MAC, scale, commit) are ever active together
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.mac, cmd.scale, cmd.commit}))
        else $error("overlapping datapath commands");
`endif

endmodule

// ===== hdl/iir_df1_ctrl.sv =====
// Sequencer for the biquad: steps the shared MAC through the taps.
// Depends on iir_df1_pkg.
module iir_df1_ctrl
    import iir_df1_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MAC    = 2'd1;
    localparam logic [1:0] ST_SCALE  = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    logic [1:0] state_reg, state_next;
    tap_t       tap_reg, tap_next;
    logic       out_valid_reg, out_valid_next;
    logic       commit;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    // hold the result in COMMIT until the output register is free
    assign commit    = (state_reg == ST_COMMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        tap_next   = tap_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MAC;
                    tap_next   = TAP_B0;
                end
            end
            ST_MAC:
            begin
                if (tap_reg == TAP_A2)
                    state_next = ST_SCALE;
                else
                    tap_next = tap_reg + tap_t'(1);
            end
            ST_SCALE:  state_next = ST_COMMIT;
            ST_COMMIT:
            begin
                if (commit)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (commit)
            out_valid_next = 1'b1;
    end

    always_comb
    begin
        cmd.load   = in_ready && in_valid;
        cmd.mac    = (state_reg == ST_MAC);
        cmd.tap    = tap_reg;
        cmd.scale  = (state_reg == ST_SCALE);
        cmd.commit = commit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tap_reg       <= TAP_B0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tap_reg       <= tap_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/iir_df1_dp.sv =====
// Datapath of the biquad: coefficients, history, shared MAC, scaling and rounding.
// Depends on iir_df1_pkg.
module iir_df1_dp
    import iir_df1_pkg::*;
#(
    parameter int FILTER_ORDER = DEF_FILTER_ORDER
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  dp_cmd_t  cmd,
    input  sample_t  sample_in,
    input  logic     cfg_we,
    input  cfg_idx_t cfg_index,
    input  coef_t    cfg_data,
    output sample_t  sample_out,
    output logic     clipped
);

    coef_t b0_reg, b1_reg, b2_reg, a1_reg, a2_reg, r_reg;

    sample_t xh_reg [FILTER_ORDER];
    sample_t yh_reg [FILTER_ORDER];
    sample_t x_reg;

    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [SCALE_W-1:0] scale_reg;
    sample_t                   y_reg;
    logic                      clip_reg;

    sample_t x1, x2, y1, y2;
    coef_t   mul_c;
    sample_t mul_s;
    logic signed [PROD_W-1:0]  prod;
    logic signed [SCALE_W-1:0] rounded;
    logic signed [Q_W-1:0]     q;
    sample_t                   y_next;
    logic                      clip_next;

    assign x1 = xh_reg[0];
    assign y1 = yh_reg[0];

    generate
        if (FILTER_ORDER >= 2)
        begin : g_two_taps
            assign x2 = xh_reg[1];
            assign y2 = yh_reg[1];
        end
        else
        begin : g_one_tap
            assign x2 = '0;
            assign y2 = '0;
        end
    endgenerate

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg <= COEF_ONE;
            b1_reg <= '0;
            b2_reg <= '0;
            a1_reg <= '0;
            a2_reg <= '0;
            r_reg  <= COEF_ONE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_B0:  b0_reg <= cfg_data;
                REG_B1:  b1_reg <= cfg_data;
                REG_B2:  b2_reg <= cfg_data;
                REG_A1:  a1_reg <= cfg_data;
                REG_A2:  a2_reg <= cfg_data;
                REG_R:   r_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // operand select for the shared multiplier
    always_comb
    begin
        case (cmd.tap)
            TAP_B0:  begin mul_c = b0_reg; mul_s = x_reg; end
            TAP_B1:  begin mul_c = b1_reg; mul_s = x1;    end
            TAP_B2:  begin mul_c = b2_reg; mul_s = x2;    end
            TAP_A1:  begin mul_c = a1_reg; mul_s = y1;    end
            TAP_A2:  begin mul_c = a2_reg; mul_s = y2;    end
            default: begin mul_c = '0;     mul_s = '0;    end
        endcase
    end

    assign prod = mul_c * mul_s;

    always_comb
    begin
        if (cmd.tap == TAP_A1 || cmd.tap == TAP_A2)
            acc_next = acc_reg - ACC_W'(prod);
        else
            acc_next = acc_reg + ACC_W'(prod);
    end

    // round half up at bit 24, then saturate
    assign rounded = scale_reg + (SCALE_W'(1) <<< (FRAC_W - 1));
    assign q       = rounded[SCALE_W-1:FRAC_W];

    always_comb
    begin
        clip_next = 1'b0;
        y_next    = q[SAMPLE_W-1:0];
        if (q > Y_MAX)
        begin
            y_next    = Y_MAX[SAMPLE_W-1:0];
            clip_next = 1'b1;
        end
        else if (q < Y_MIN)
        begin
            y_next    = Y_MIN[SAMPLE_W-1:0];
            clip_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg   <= sample_in;
            acc_reg <= '0;
        end
        else if (cmd.mac)
            acc_reg <= acc_next;
        if (cmd.scale)
            scale_reg <= SCALE_W'(acc_reg) * SCALE_W'(r_reg);
        if (cmd.commit)
        begin
            y_reg    <= y_next;
            clip_reg <= clip_next;
        end
    end

    // history lines, newest at entry 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < FILTER_ORDER; k++)
            begin
                xh_reg[k] <= '0;
                yh_reg[k] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            for (int k = FILTER_ORDER - 1; k > 0; k--)
            begin
                xh_reg[k] <= xh_reg[k-1];
                yh_reg[k] <= yh_reg[k-1];
            end
            xh_reg[0] <= x_reg;
            yh_reg[0] <= y_next;
        end
    end

    assign sample_out = y_reg;
    assign clipped    = clip_reg;

endmodule

// ===== tb/iir_direct_form_one_filter_tb.sv =====
// Self-checking testbench for the direct-form-I biquad: drives samples and register
// writes, predicts each filtered sample and compares the results channel field by field.
// Depends on iir_df1_pkg, the channel interfaces and iir_direct_form_one_filter.
module iir_direct_form_one_filter_tb;
    import iir_df1_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int RESET_LEN   = 12;
    localparam int TIMEOUT     = 4_000_000;
    // margin on top of the time one sample takes inside the block
    localparam int SETTLE_LEN  = 16;
    localparam int HOLD_OFF    = 150;
    localparam int PHASE_COUNT = 10;
    localparam int PHASE_ITEMS = 95;

    localparam sample_t SAMPLE_MAX = 16'sh7FFF;
    localparam sample_t SAMPLE_MIN = 16'sh8000;
    localparam coef_t   COEF_MAX   = 16'sh7FFF;
    localparam coef_t   COEF_MIN   = 16'sh8000;
    localparam coef_t   COEF_HALF  = 16'sd2048;
    localparam coef_t   COEF_ZERO  = 16'sd0;

    // indexes past the last register: the block must ignore writes to them
    localparam cfg_idx_t UNUSED_IDX_LO = REG_R + 3'd1;
    localparam cfg_idx_t UNUSED_IDX_HI = 3'd7;

    localparam logic signed [SCALE_W-1:0] ROUND_HALF = SCALE_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [Q_W-1:0]     SAT_HI     = Q_W'(32767);
    localparam logic signed [Q_W-1:0]     SAT_LO     = -Q_W'(32768);

    typedef struct packed {
        sample_t level;
        logic    clipped;
    } filtered_t;

    logic clk = 1'b0;
    logic rst_n;

    iir_df1_in_if  in_if();
    iir_df1_out_if out_if();
    iir_df1_cfg_if cfg_if();

    iir_direct_form_one_filter u_top
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (in_if),
        .results (out_if),
        .cfg     (cfg_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Predictor state: coefficients as last written, plus the two-deep histories.
    // Entry 0 of each history is the newest.
    coef_t   coefs [REG_B0:REG_R];
    sample_t x_hist [0:1];
    sample_t y_hist [0:1];

    filtered_t pending_outputs [$];
    int        failures    = 0;
    int        hold_cycles = 0;
    bit        idle_on     = 1'b1;

    // Work out the filtered sample for input x and advance the histories.
    // The tap sum is exact at 34 bits, the scaled sum exact at 50 bits; the
    // arithmetic shift floors, so adding half first rounds half upwards.
    function automatic filtered_t biquad_predict(sample_t x);
        logic signed [ACC_W-1:0]   tap_sum;
        logic signed [SCALE_W-1:0] scaled;
        logic signed [Q_W-1:0]     rounded;
        filtered_t                 res;
        tap_sum = coefs[REG_B0] * x
                + coefs[REG_B1] * x_hist[0]
                + coefs[REG_B2] * x_hist[1]
                - coefs[REG_A1] * y_hist[0]
                - coefs[REG_A2] * y_hist[1];
        scaled  = tap_sum * coefs[REG_R] + ROUND_HALF;
        rounded = Q_W'(scaled >>> FRAC_W);
        res.clipped = 1'b1;
        if (rounded > SAT_HI)
            res.level = SAMPLE_MAX;
        else if (rounded < SAT_LO)
            res.level = SAMPLE_MIN;
        else
        begin
            res.level   = sample_t'(rounded);
            res.clipped = 1'b0;
        end
        x_hist[1] = x_hist[0];
        x_hist[0] = x;
        y_hist[1] = y_hist[0];
        y_hist[0] = res.level;
        return res;
    endfunction

    function automatic coef_t rand_coef(int span);
        return coef_t'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // Mostly full-range samples, some small ones near zero, a few at the rails.
    function automatic sample_t random_sample();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            return sample_t'($urandom);
        if (pick < 17)
            return sample_t'(int'($urandom_range(0, 512)) - 256);
        return ($urandom_range(0, 1) == 1) ? SAMPLE_MAX : SAMPLE_MIN;
    endfunction

    // Offer one sample after a random gap; keep valid high when there is no gap so
    // back-to-back items stream. Predict on acceptance.
    task automatic send_sample(sample_t x);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.sample_in <= x;
        @(posedge clk);
        while (in_if.ready !== 1'b1)
            @(posedge clk);
        pending_outputs.push_back(biquad_predict(x));
    endtask

    // Drop the sample valid and hold until every predicted result has been taken.
    // Each sample yields exactly one result, so an empty store means the block is idle.
    task automatic wait_all_results();
        in_if.valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
    endtask

    // Present one register write and hold it until taken; valid stays high so
    // consecutive writes stream without a gap. Callers lower it afterwards.
    task automatic write_reg(cfg_idx_t idx, coef_t val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (cfg_if.ready !== 1'b1)
            @(posedge clk);
        if (idx <= REG_R)
            coefs[idx] = val;
    endtask

    // Close a run of register writes.
    task automatic end_writes();
        cfg_if.valid <= 1'b0;
    endtask

    task automatic program_filter(coef_t b0, coef_t b1, coef_t b2,
                                  coef_t a1, coef_t a2, coef_t r);
        write_reg(REG_B0, b0);
        write_reg(REG_B1, b1);
        write_reg(REG_B2, b2);
        write_reg(REG_A1, a1);
        write_reg(REG_A2, a2);
        write_reg(REG_R,  r);
    endtask

    task automatic write_unknown_reg(cfg_idx_t idx, coef_t val);
        write_reg(idx, val);
    endtask

    // After reset the filter is the identity: every sample must come back unchanged.
    task automatic test_identity_after_reset();
        send_sample(16'sd0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sh5555);
        wait_all_results();
    endtask

    // b0 = 0.5 puts odd samples exactly half way: +1.5 rounds to 2, -1.5 to -1.
    task automatic test_half_rounding();
        program_filter(COEF_HALF, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE);
        end_writes();
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sd3);
        send_sample(-16'sd3);
        wait_all_results();
    endtask

    // Every coefficient at one rail, samples at the rails: drives saturation both
    // ways and pushes saturated values through the feedback taps.
    task automatic test_coef_extremes();
        program_filter(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        end_writes();
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        wait_all_results();
        program_filter(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        end_writes();
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        wait_all_results();
    endtask

    // A zero reciprocal must give zero, whatever the taps hold.
    task automatic test_zero_reciprocal();
        program_filter(rand_coef(32767), rand_coef(32767), rand_coef(32767),
                       rand_coef(32767), rand_coef(32767), COEF_ZERO);
        end_writes();
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(16'sh1234);
        wait_all_results();
    endtask

    // Writes past the last register must leave the identity filter untouched.
    task automatic test_unknown_index();
        program_filter(COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE);
        write_unknown_reg(UNUSED_IDX_LO, COEF_ZERO);
        write_unknown_reg(UNUSED_IDX_HI, COEF_MAX);
        end_writes();
        send_sample(16'sh7F00);
        send_sample(-16'sd300);
        send_sample(16'sh00FF);
        wait_all_results();
    endtask

    // Phases of random samples, each under its own coefficient set: gentle
    // filters, fully random sets, sets of rails and zeros, and strong feedback.
    task automatic test_random_settings();
        int          phase;
        int          n;
        coef_t       rail [0:2];
        coef_t       pick [0:5];
        rail[0] = COEF_MAX;
        rail[1] = COEF_MIN;
        rail[2] = COEF_ZERO;
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    program_filter(rand_coef(2048), rand_coef(2048), rand_coef(2048),
                                   rand_coef(3000), coef_t'($urandom_range(0, 1500)),
                                   coef_t'($urandom_range(2048, 8192)));
                end
                1:
                begin
                    program_filter(coef_t'($urandom), coef_t'($urandom), coef_t'($urandom),
                                   coef_t'($urandom), coef_t'($urandom), coef_t'($urandom));
                end
                2:
                begin
                    for (n = 0; n < 6; n++)
                        pick[n] = rail[$urandom_range(0, 2)];
                    program_filter(pick[0], pick[1], pick[2], pick[3], pick[4], pick[5]);
                end
                default:
                begin
                    program_filter(rand_coef(8192), rand_coef(8192), rand_coef(8192),
                                   rand_coef(8192), rand_coef(4096), rand_coef(32767));
                end
            endcase
            if ($urandom_range(0, 2) == 0)
                write_unknown_reg(cfg_idx_t'($urandom_range(UNUSED_IDX_LO, UNUSED_IDX_HI)),
                                  coef_t'($urandom));
            end_writes();
            // every third phase streams with no idling on either side
            idle_on = (phase % 3 != 2);
            for (n = 0; n < PHASE_ITEMS; n++)
                send_sample(random_sample());
            wait_all_results();
        end
        idle_on = 1'b1;
    endtask

    // Hold the results channel off for a long stretch while samples keep coming,
    // so the output register fills, the next sample waits in commit and the input stalls.
    task automatic test_output_backpressure();
        int n;
        program_filter(rand_coef(2048), rand_coef(2048), rand_coef(2048),
                       rand_coef(2048), rand_coef(1024), COEF_ONE);
        end_writes();
        idle_on     = 1'b0;
        hold_cycles = HOLD_OFF;
        for (n = 0; n < 40; n++)
            send_sample(random_sample());
        wait_all_results();
        idle_on = 1'b1;
    endtask

    // Results side: take each item, compare against the oldest prediction, then
    // draw a fresh stall. A requested hold-off takes priority and counts down here.
    initial
    begin : result_checker
        int unsigned stall;
        filtered_t   want;
        stall = 0;
        out_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
            begin
                if (pending_outputs.size() == 0)
                begin
                    $display("%0t: result with nothing expected: sample_out %0d clipped %0b",
                             $time, out_if.sample_out, out_if.clipped);
                    failures++;
                end
                else
                begin
                    want = pending_outputs.pop_front();
                    if (out_if.sample_out !== want.level)
                    begin
                        $display("%0t: sample_out expected %0d got %0d",
                                 $time, want.level, out_if.sample_out);
                        failures++;
                    end
                    if (out_if.clipped !== want.clipped)
                    begin
                        $display("%0t: clipped expected %0b got %0b",
                                 $time, want.clipped, out_if.clipped);
                        failures++;
                    end
                end
                stall = idle_on ? $urandom_range(0, 3) : 0;
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_if.ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                out_if.ready <= 1'b0;
            end
            else
                out_if.ready <= 1'b1;
        end
    end

    initial
    begin
        #(TIMEOUT);
        $display("iir_direct_form_one_filter_tb NOT OK");
        $finish;
    end

    initial
    begin
        // hold every input at a known value from time zero
        rst_n           <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.sample_in <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= REG_B0;
        cfg_if.data     <= '0;

        // predictor starts from the reset state: identity filter, empty history
        coefs[REG_B0] = COEF_ONE;
        coefs[REG_B1] = COEF_ZERO;
        coefs[REG_B2] = COEF_ZERO;
        coefs[REG_A1] = COEF_ZERO;
        coefs[REG_A2] = COEF_ZERO;
        coefs[REG_R]  = COEF_ONE;
        x_hist[0] = '0;
        x_hist[1] = '0;
        y_hist[0] = '0;
        y_hist[1] = '0;

        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_identity_after_reset();
        test_half_rounding();
        test_coef_extremes();
        test_zero_reciprocal();
        test_unknown_index();
        test_random_settings();
        test_output_backpressure();

        wait_all_results();
        repeat (SETTLE_LEN) @(posedge clk);
        if (failures == 0 && pending_outputs.size() == 0)
            $display("iir_direct_form_one_filter_tb OK");
        else
            $display("iir_direct_form_one_filter_tb NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/iir_df1_pkg.sv
hdl/iir_df1_ifs.sv
hdl/iir_df1_ctrl.sv
hdl/iir_df1_dp.sv
hdl/iir_direct_form_one_filter.sv
tb/iir_direct_form_one_filter_tb.sv
